### rtl/smacd_pkg.sv
// ----------------------------------------------------------------------------
// smacd_pkg
// Shared constants and types for the moving-average crossover detector.
// ----------------------------------------------------------------------------
package smacd_pkg;

   localparam int PRICE_W          = 32;
   localparam int SHORT_PERIOD_DEF = 5;
   localparam int LONG_PERIOD_DEF  = 10;

   // status of the window state after the latest update
   typedef struct packed {
      logic warm;      // more bars than the longer period seen
      logic prev_nz;   // both sums before this bar were non-zero
   } smacd_stat_type;

endpackage
// ----------------------------------------------------------------------------

### rtl/smacd_req_if.sv
// ----------------------------------------------------------------------------
// smacd_req_if
// Bar transaction channel: one closing price and a new-series flag.
// ----------------------------------------------------------------------------
interface smacd_req_if;
   import smacd_pkg::*;

   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] price;
   logic               first_bar;

   modport source (output valid, output price, output first_bar, input ready);
   modport sink   (input valid, input price, input first_bar, output ready);

endinterface
// ----------------------------------------------------------------------------

### rtl/smacd_rsp_if.sv
// ----------------------------------------------------------------------------
// smacd_rsp_if
// Result transaction channel: crossover flags for one bar.
// ----------------------------------------------------------------------------
interface smacd_rsp_if;

   logic valid;
   logic ready;
   logic buy;
   logic sell;
   logic ready_res;

   modport source (output valid, output buy, output sell, output ready_res, input ready);
   modport sink   (input valid, input buy, input sell, input ready_res, output ready);

endinterface
// ----------------------------------------------------------------------------

### rtl/smacd_window.sv
// ----------------------------------------------------------------------------
// smacd_window
// Price window with incrementally updated short and long sums.
// ----------------------------------------------------------------------------
module smacd_window import smacd_pkg::*; #(
   parameter int SHORT_PERIOD = SHORT_PERIOD_DEF,
   parameter int LONG_PERIOD  = LONG_PERIOD_DEF,
   localparam int SUM_S_W     = PRICE_W + $clog2(SHORT_PERIOD),
   localparam int SUM_L_W     = PRICE_W + $clog2(LONG_PERIOD)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               upd,
   input  logic [PRICE_W-1:0] price,
   input  logic               first_bar,
   output logic [SUM_S_W-1:0] short_sum,
   output logic [SUM_L_W-1:0] long_sum,
   output smacd_stat_type     stat
);

   localparam int MAX_P  = (SHORT_PERIOD > LONG_PERIOD) ? SHORT_PERIOD : LONG_PERIOD;
   localparam int BARS_W = $clog2(MAX_P + 2);

   logic [PRICE_W-1:0] win_ff [MAX_P];
   logic [PRICE_W-1:0] win_in [MAX_P];
   logic [SUM_S_W-1:0] short_ff, short_in;
   logic [SUM_L_W-1:0] long_ff, long_in;
   logic [BARS_W-1:0]  bars_ff, bars_in, bars_base;
   logic               prev_nz_ff, prev_nz_in;
   logic [PRICE_W-1:0] drop_s, drop_l;
   logic [SUM_S_W-1:0] short_base;
   logic [SUM_L_W-1:0] long_base;

   always_comb begin
      // a new series behaves as if the window and counts were all zero
      drop_s     = first_bar ? '0 : win_ff[SHORT_PERIOD-1];
      drop_l     = first_bar ? '0 : win_ff[LONG_PERIOD-1];
      short_base = first_bar ? '0 : short_ff;
      long_base  = first_bar ? '0 : long_ff;
      bars_base  = first_bar ? '0 : bars_ff;

      win_in[0] = price;
      for (int i = 1; i < MAX_P; i++) begin
         win_in[i] = first_bar ? '0 : win_ff[i-1];
      end

      short_in = short_base + SUM_S_W'(price) - SUM_S_W'(drop_s);
      long_in  = long_base + SUM_L_W'(price) - SUM_L_W'(drop_l);

      if (bars_base < BARS_W'(MAX_P + 1)) begin
         bars_in = bars_base + BARS_W'(1);
      end else begin
         bars_in = bars_base;
      end

      prev_nz_in = (short_base != '0) && (long_base != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_P; i++) begin
            win_ff[i] <= '0;
         end
         short_ff   <= '0;
         long_ff    <= '0;
         bars_ff    <= '0;
         prev_nz_ff <= 1'b0;
      end else if (upd) begin
         win_ff     <= win_in;
         short_ff   <= short_in;
         long_ff    <= long_in;
         bars_ff    <= bars_in;
         prev_nz_ff <= prev_nz_in;
      end
   end

   assign short_sum    = short_ff;
   assign long_sum     = long_ff;
   assign stat.warm    = (bars_ff > BARS_W'(MAX_P));
   assign stat.prev_nz = prev_nz_ff;

endmodule
// ----------------------------------------------------------------------------

### rtl/sma_crossover_detector.sv
// ----------------------------------------------------------------------------
// sma_crossover_detector
// Short/long SMA crossover detector, one bar per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
// Path: req passes the input, window and result registers to rsp.
// Throughput: one bar per cycle unless rsp stalls; the window sums take
//   one add and one subtract per bar; the compare uses constant multiplies.
// Reset: synchronous, active high; clears the window, sums, bar count and
//   all pipeline valids. The block takes transactions right after reset.
// ----------------------------------------------------------------------------
module sma_crossover_detector import smacd_pkg::*; #(
   parameter int SHORT_PERIOD = SHORT_PERIOD_DEF,
   parameter int LONG_PERIOD  = LONG_PERIOD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   smacd_req_if.sink   req_ch,
   smacd_rsp_if.source rsp_ch
);

   localparam int SUM_S_W = PRICE_W + $clog2(SHORT_PERIOD);
   localparam int SUM_L_W = PRICE_W + $clog2(LONG_PERIOD);
   // both products are at most sum * period, well inside this width
   localparam int PROD_W  = PRICE_W + $clog2(SHORT_PERIOD) + $clog2(LONG_PERIOD) + 1;

   // Pipeline:
   //   stage 1: input register (price, first_bar)
   //   stage 2: window state, updated as the bar moves in
   //   stage 3: result register with the crossover flags
   logic               v1_ff, v2_ff, v3_ff;
   logic               en1, en2, en3;
   logic [PRICE_W-1:0] price_ff;
   logic               first_ff;

   logic [SUM_S_W-1:0] short_sum;
   logic [SUM_L_W-1:0] long_sum;
   smacd_stat_type     stat;

   // compare sign of the bar that last left stage 2 (the previous bar)
   logic               last_gt_ff, last_gt_in;
   logic               last_lt_ff, last_lt_in;
   logic               buy_ff, buy_in;
   logic               sell_ff, sell_in;
   logic               rdy_ff, rdy_in;

   logic [PROD_W-1:0]  prod_s, prod_l;
   logic               now_gt, now_lt;

   // Back-pressure: each stage moves when it is empty or the next one moves.
   assign en3 = !v3_ff || rsp_ch.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         price_ff <= req_ch.price;
         first_ff <= req_ch.first_bar;
      end
   end

   smacd_window #(
      .SHORT_PERIOD (SHORT_PERIOD),
      .LONG_PERIOD  (LONG_PERIOD)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .upd       (en2 && v1_ff),
      .price     (price_ff),
      .first_bar (first_ff),
      .short_sum (short_sum),
      .long_sum  (long_sum),
      .stat      (stat)
   );

   // Exact average compare: short/S > long/L  <=>  short*L > long*S.
   always_comb begin
      prod_s = PROD_W'(short_sum) * PROD_W'(LONG_PERIOD);
      prod_l = PROD_W'(long_sum) * PROD_W'(SHORT_PERIOD);
      now_gt = prod_s > prod_l;
      now_lt = prod_s < prod_l;

      // valid only once warmed up and with all four sums non-zero
      rdy_in = stat.warm && stat.prev_nz && (short_sum != '0) && (long_sum != '0);
      // before <= 0 is "not greater"; before >= 0 is "not less"
      buy_in  = rdy_in && !last_gt_ff && now_gt;
      sell_in = rdy_in && !last_lt_ff && now_lt;

      last_gt_in = now_gt;
      last_lt_in = now_lt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_gt_ff <= 1'b0;
         last_lt_ff <= 1'b0;
      end else if (en3 && v2_ff) begin
         last_gt_ff <= last_gt_in;
         last_lt_ff <= last_lt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         buy_ff  <= buy_in;
         sell_ff <= sell_in;
         rdy_ff  <= rdy_in;
      end
   end

   assign rsp_ch.valid     = v3_ff;
   assign rsp_ch.buy       = buy_ff;
   assign rsp_ch.sell      = sell_ff;
   assign rsp_ch.ready_res = rdy_ff;

endmodule
// ----------------------------------------------------------------------------

### test/tb_sma_crossover_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sma_crossover_detector
// Self-checking bench for the 5/10 bar moving-average crossover detector.
// Bars go in through the req channel; a local predictor of the price window
// and its sums computes buy, sell and ready_res for every accepted bar.
// Each rsp transaction is compared in order against those predictions.
// Both channels idle at random; one phase holds the result side off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_sma_crossover_detector;
   import smacd_pkg::*;

   localparam int SHORT_N     = SHORT_PERIOD_DEF;
   localparam int LONG_N      = LONG_PERIOD_DEF;
   localparam int WIN_N       = (LONG_N > SHORT_N) ? LONG_N : SHORT_N;
   localparam int PIPE_LAT    = 3;        // req to rsp, in the block's register stages
   localparam int STALL_LIMIT = 2000;     // cycles with no transaction at all
   localparam int HOLD_CYCLES = 150;      // long result-side hold-off
   localparam int GAP_MAX     = 17;
   localparam int MAX_SHOWN   = 10;

   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
   localparam longint PRICE_TOP = 64'h0000_0000_FFFF_FFFF;

   // flags predicted for one bar
   typedef struct packed {
      logic buy;
      logic sell;
      logic ready_res;
   } bar_flags_t;

   logic clock;
   logic reset;

   smacd_req_if req_ch ();
   smacd_rsp_if rsp_ch ();

   sma_crossover_detector #(
      .SHORT_PERIOD (SHORT_N),
      .LONG_PERIOD  (LONG_N)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // ------------------------------------------------------------------------
   // predictor state: newest close at index 0
   // ------------------------------------------------------------------------
   logic [PRICE_W-1:0] closes [WIN_N];
   logic [34:0]        sum_short;
   logic [35:0]        sum_long;
   logic [34:0]        sum_short_prev;
   logic [35:0]        sum_long_prev;
   int                 bar_count;

   bar_flags_t flags_due [$];    // predictions waiting for their rsp transaction
   bar_flags_t flags_want;
   bar_flags_t flags_got;

   int mismatch_count = 0;
   int rsp_seen       = 0;
   int items_sent     = 0;
   int idle_cycles    = 0;
   int tx_gap_max     = 0;
   int rx_gap_max     = 0;
   int rx_hold_cycles = 0;

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // -1, 0, +1: short average below, equal to, above long average.
   // Cross-multiplied by the periods so no division is needed.
   function automatic int avg_order(input logic [35:0] s_sum, input logic [35:0] l_sum);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = 64'(s_sum) * 64'(LONG_N);
      rhs = 64'(l_sum) * 64'(SHORT_N);
      if (lhs > rhs)
         return 1;
      if (lhs < rhs)
         return -1;
      return 0;
   endfunction

   task automatic predict_crossover(input logic [PRICE_W-1:0] px, input logic new_series,
                                    output bar_flags_t flags);
      int i;
      int order_prev;
      int order_now;
      if (new_series) begin
         for (i = 0; i < WIN_N; i++)
            closes[i] = '0;
         sum_short = '0;
         sum_long  = '0;
         bar_count = 0;
      end
      // previous sums are taken after a new-series clear, so they are zero then
      sum_short_prev = sum_short;
      sum_long_prev  = sum_long;

      for (i = WIN_N - 1; i > 0; i--)
         closes[i] = closes[i-1];
      closes[0] = px;

      sum_short = '0;
      sum_long  = '0;
      for (i = 0; i < SHORT_N; i++)
         sum_short = sum_short + 35'(closes[i]);
      for (i = 0; i < LONG_N; i++)
         sum_long = sum_long + 36'(closes[i]);

      if (bar_count <= WIN_N)
         bar_count++;

      flags.ready_res = (bar_count > WIN_N) && (sum_short != 0) && (sum_long != 0) &&
                        (sum_short_prev != 0) && (sum_long_prev != 0);
      flags.buy  = 1'b0;
      flags.sell = 1'b0;
      if (flags.ready_res) begin
         order_prev = avg_order(36'(sum_short_prev), sum_long_prev);
         order_now  = avg_order(36'(sum_short), sum_long);
         // equality before lets either direction through; equality now blocks both
         flags.buy  = (order_prev <= 0) && (order_now > 0);
         flags.sell = (order_prev >= 0) && (order_now < 0);
      end
   endtask

   // ------------------------------------------------------------------------
   // sender: one req transaction, predicted on acceptance
   // ------------------------------------------------------------------------
   task automatic send_bar(input logic [PRICE_W-1:0] px, input logic new_series);
      int gap;
      bar_flags_t flags;
      gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.price     <= px;
      req_ch.first_bar <= new_series;
      do @(posedge clock); while (!req_ch.ready);
      predict_crossover(px, new_series, flags);
      flags_due.push_back(flags);
      items_sent++;
   endtask

   // sender stops and waits for every outstanding result, then lets the pipe settle
   task automatic wait_all_results;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (flags_due.size() != 0)
         @(posedge clock);
      repeat (PIPE_LAT * 4) @(posedge clock);
   endtask

   // random walk on the full price range, clamped at both ends
   function automatic logic [PRICE_W-1:0] walk_price(input logic [PRICE_W-1:0] px,
                                                     input int unsigned step_max);
      longint delta;
      longint nxt;
      delta = longint'($urandom_range(0, step_max));
      if ($urandom_range(0, 1) == 0)
         delta = -delta;
      nxt = longint'(px) + delta;
      if (nxt < 0)
         nxt = 0;
      else if (nxt > PRICE_TOP)
         nxt = PRICE_TOP;
      return nxt[PRICE_W-1:0];
   endfunction

   // one well-formed series: first bar, then a walk with flat and zero stretches
   task automatic run_series(input int n_bars, input logic [PRICE_W-1:0] start_px,
                             input int unsigned step_max);
      logic [PRICE_W-1:0] px;
      int k;
      int pick;
      int flat_left;
      int zero_left;
      px        = start_px;
      flat_left = 0;
      zero_left = 0;
      send_bar(px, 1'b1);
      for (k = 1; k < n_bars; k++) begin
         pick = $urandom_range(0, 99);
         if (flat_left == 0 && zero_left == 0) begin
            if (pick < 6)
               flat_left = $urandom_range(3, 12);    // flat prices, equal averages once long enough
            else if (pick < 9)
               zero_left = $urandom_range(1, 12);    // zero prices, zero sums once long enough
         end
         if (zero_left > 0) begin
            zero_left--;
            send_bar('0, 1'b0);
         end else begin
            if (flat_left > 0)
               flat_left--;
            else
               px = walk_price(px, step_max);
            send_bar(px, 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // test tasks
   // ------------------------------------------------------------------------

   // full-scale flat series: warm-up keeps flags low, then equal averages
   task automatic test_warmup_equal;
      tx_gap_max = 0;
      rx_gap_max = 0;
      send_bar(PRICE_MAX, 1'b1);
      repeat (10) send_bar(PRICE_MAX, 1'b0);
   endtask

   // sell out of equal averages, short sum at zero, then a buy on recovery
   task automatic test_cross_and_zero;
      tx_gap_max = GAP_MAX;
      rx_gap_max = GAP_MAX;
      send_bar('0, 1'b0);
      repeat (4) send_bar('0, 1'b0);
      send_bar(PRICE_W'(1), 1'b0);
      repeat (3) send_bar(PRICE_MAX, 1'b0);
      // new series in the middle of a warm window
      send_bar(PRICE_W'(32'h5555_5555), 1'b1);
      send_bar(PRICE_W'(32'hAAAA_AAAA), 1'b0);
      wait_all_results;
   endtask

   // bulk of the run: many series with random level, volatility and idling
   task automatic test_random_series;
      int unsigned step_max;
      logic [PRICE_W-1:0] start_px;
      while (items_sent < 1250) begin
         case ($urandom_range(0, 3))
            0: begin tx_gap_max = 0;       rx_gap_max = 0;       end
            1: begin tx_gap_max = GAP_MAX; rx_gap_max = 0;       end
            2: begin tx_gap_max = 0;       rx_gap_max = GAP_MAX; end
            default: begin tx_gap_max = GAP_MAX; rx_gap_max = GAP_MAX; end
         endcase
         case ($urandom_range(0, 2))
            0: start_px = PRICE_W'($urandom_range(0, 2000));
            1: start_px = PRICE_W'($urandom_range(1000000, 50000000));
            default: start_px = PRICE_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: step_max = 3;
            1: step_max = 500;
            2: step_max = 1 << 20;
            default: step_max = 1 << 28;
         endcase
         run_series($urandom_range(12, 80), start_px, step_max);
      end
      wait_all_results;
   endtask

   // result side holds off while bars keep coming, so the block stalls req
   task automatic test_backpressure;
      tx_gap_max     = 0;
      rx_gap_max     = 0;
      rx_hold_cycles = HOLD_CYCLES;
      run_series(80, PRICE_W'($urandom_range(100000, 200000)), 5000);
      wait_all_results;
   endtask

   // broken series: random full-range prices and scattered new-series flags
   task automatic test_noise;
      int k;
      logic [PRICE_W-1:0] px;
      tx_gap_max = GAP_MAX;
      rx_gap_max = GAP_MAX;
      for (k = 0; k < 250; k++) begin
         case ($urandom_range(0, 9))
            0: px = '0;
            1: px = PRICE_MAX;
            default: px = PRICE_W'($urandom);
         endcase
         if (k == 125) begin
            tx_gap_max = 0;
            rx_gap_max = 0;
         end
         send_bar(px, ($urandom_range(0, 15) == 0));
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: random stalls plus the long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_drive
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            while (rx_hold_cycles > 0) begin
               @(negedge clock);
               rx_hold_cycles--;
            end
         end
         gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // checker: every rsp transaction against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         flags_got.buy       = rsp_ch.buy;
         flags_got.sell      = rsp_ch.sell;
         flags_got.ready_res = rsp_ch.ready_res;
         if (flags_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("result %0d with none expected: buy=%b sell=%b ready_res=%b",
                        rsp_seen, flags_got.buy, flags_got.sell, flags_got.ready_res);
         end else begin
            flags_want = flags_due.pop_front();
            if (flags_got !== flags_want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("result %0d: expected buy=%b sell=%b ready_res=%b, got %b %b %b",
                           rsp_seen, flags_want.buy, flags_want.sell, flags_want.ready_res,
                           flags_got.buy, flags_got.sell, flags_got.ready_res);
            end
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any transaction on either channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.price     = '0;
      req_ch.first_bar = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_warmup_equal;
      test_cross_and_zero;
      test_random_series;
      test_backpressure;
      test_noise;
      wait_all_results;

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
// ----------------------------------------------------------------------------
